FILE: rtl/plnf_pkg.sv
package plnf_pkg;

   localparam int MaxTapsDefault = 1024;
   localparam logic [15:0] AlphaReset = 16'hF000;
   localparam logic [30:0] ThreshReset = 31'd859;

   localparam logic CsrAlpha = 1'b0;
   localparam logic CsrThresh = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BUILD_MUL,
      ST_BUILD_DIV,
      ST_BUILD_RND,
      ST_BUILD_WR,
      ST_MAC_RD,
      ST_MAC_WAIT,
      ST_MAC_MUL,
      ST_MAC_ACC,
      ST_FINISH,
      ST_OUT
   } state_type;

   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
      return s;
   endfunction

endpackage

FILE: rtl/plnf_divider.sv
module plnf_divider
   import plnf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);

   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [64:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = '0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff, quo_ff[63]} - {1'b0, divisor};
         if (!trial[64]) begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[62:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = busy_ff && cnt_ff == 7'd1;
   assign quotient = {quo_ff[62:0], ~trial[64]};

endmodule

FILE: rtl/plnf_ram.sv
module plnf_ram
   import plnf_pkg::*;
#(
   parameter int Depth = MaxTapsDefault,
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data
);

   logic [31:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: rtl/power_law_noise_ar_filter.sv
// channel | dir | valid/ready           | payload
// req     | in  | req_valid/req_ready   | req_white_sample[23:0]
// rsp     | out | rsp_valid/rsp_ready   | rsp_colored_sample[31:0], rsp_saturated
// csr     | in  | csr_valid/csr_ready   | csr_index, csr_data[30:0]
//
// One item at a time. First item after reset builds the coefficient table:
// per coefficient a test-and-write, one multiply, a rounding add, then a
// restoring divide (up to MaxTaps coefficients).
// Each item then runs N = used taps (<= MaxTaps-1) before rsp_valid
// through one shared multiply-accumulate: per tap a registered memory
// read, product and accumulate.
// Synchronous reset; memories are not cleared (never read before written).
// A stalled result holds the block; req_ready is low until it is taken.
module power_law_noise_ar_filter
   import plnf_pkg::*;
#(
   parameter int MaxTaps = MaxTapsDefault,
   localparam int AW = (MaxTaps > 1) ? $clog2(MaxTaps) : 1,
   localparam int CW = $clog2(MaxTaps + 1)
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [23:0] req_white_sample,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_colored_sample,
   output logic        rsp_saturated,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [30:0] csr_data
);

   state_type state_ff, state_in;

   logic [15:0] alpha_ff;
   logic [30:0] thresh_ff;
   logic        ready_ff, ready_in;
   logic [CW-1:0] taps_ff, taps_in;     // coefficients stored
   logic [CW-1:0] seen_ff, seen_in;     // saturates at MaxTaps
   logic [AW-1:0] wp_ff, wp_in;
   logic [CW-1:0] i_ff, i_in;           // tap / build index
   logic [CW-1:0] n_ff, n_in;
   logic signed [31:0] b_ff, b_in;      // current coefficient during build
   logic signed [23:0] w_ff, w_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [63:0] m_ff, m_in;
   logic        neg_ff, neg_in;
   logic [31:0] y_ff, y_in;
   logic        sat_ff, sat_in;

   // build arithmetic
   logic signed [31:0] f_val;
   logic [31:0] f_mag, b_mag;
   logic        div_start, div_done;
   logic [63:0] div_q, div_d;
   logic [63:0] q_ff, q_in;

   // memories
   logic          cw_en, hw_en;
   logic [AW-1:0] c_waddr, c_raddr, h_raddr;
   logic [31:0]   c_rdata, h_rdata;
   logic [31:0]   c_wdata;

   logic signed [63:0] xs;
   logic [63:0] xm, qo;

   plnf_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(m_ff), .divisor(div_d), .done(div_done), .quotient(div_q)
   );

   plnf_ram #(.Depth(MaxTaps)) u_coef (
      .clock(clock), .wr_en(cw_en), .wr_addr(c_waddr), .wr_data(c_wdata),
      .rd_addr(c_raddr), .rd_data(c_rdata)
   );

   // ring spans the full pointer range so wrap stays consistent
   plnf_ram #(.Depth(2 ** AW)) u_hist (
      .clock(clock), .wr_en(hw_en), .wr_addr(wp_ff), .wr_data(y_ff),
      .rd_addr(h_raddr), .rd_data(h_rdata)
   );

   assign csr_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff  <= AlphaReset;
         thresh_ff <= ThreshReset;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CsrAlpha) alpha_ff <= csr_data[15:0];
         else thresh_ff <= csr_data;
      end
   end

   // f = (i-1)<<13 + alpha, divisor i<<13
   assign f_val = (32'(signed'({1'b0, i_ff - CW'(1)})) <<< 13) + 32'(signed'(alpha_ff));
   assign f_mag = f_val[31] ? 32'(-f_val) : f_val;
   assign b_mag = b_ff[31] ? 32'(-b_ff) : b_ff;
   assign div_d = 64'(i_ff) << 13;

   assign c_waddr = AW'(taps_ff);
   assign c_wdata = b_ff;
   assign c_raddr = AW'(i_ff);
   assign h_raddr = wp_ff - AW'(i_ff);

   always_comb begin
      xs = sat_add64(64'(w_ff) <<< 30,
                     acc_ff == {1'b1, 63'd0} ? {1'b0, {63{1'b1}}} : -acc_ff);
      xm = xs[63] ? 64'(-xs) : xs;
      qo = (xm >> 30) + 64'(xm[29]);
   end

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      taps_in  = taps_ff;
      seen_in  = seen_ff;
      wp_in    = wp_ff;
      i_in     = i_ff;
      n_in     = n_ff;
      b_in     = b_ff;
      w_in     = w_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      m_in     = m_ff;
      neg_in   = neg_ff;
      q_in     = q_ff;
      y_in     = y_ff;
      sat_in   = sat_ff;
      div_start = 1'b0;
      cw_en    = 1'b0;
      hw_en    = 1'b0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               w_in   = req_white_sample;
               acc_in = '0;
               if (!ready_ff) begin
                  b_in    = 32'sd1 <<< 30;
                  taps_in = '0;
                  state_in = ST_BUILD_WR;
               end else begin
                  i_in = CW'(1);
                  n_in = (taps_ff == 0) ? '0 :
                         ((seen_ff < taps_ff - CW'(1)) ? seen_ff : taps_ff - CW'(1));
                  state_in = ST_MAC_RD;
               end
            end
         end
         ST_BUILD_WR: begin
            // store b if it passes, else table done
            if (taps_ff < CW'(MaxTaps) && ({32'd0, b_mag} << 2) > 64'(thresh_ff)) begin
               cw_en   = 1'b1;
               taps_in = taps_ff + CW'(1);
               i_in    = taps_ff + CW'(1);
               if (taps_ff + CW'(1) < CW'(MaxTaps)) state_in = ST_BUILD_MUL;
               else begin
                  ready_in = 1'b1;
                  i_in = CW'(1);
                  n_in = '0;
                  state_in = ST_MAC_RD;
               end
            end else begin
               ready_in = 1'b1;
               i_in = CW'(1);
               n_in = '0;
               state_in = ST_MAC_RD;
            end
         end
         ST_BUILD_MUL: begin
            m_in   = 64'(b_mag) * 64'(f_mag);
            neg_in = b_ff[31] != f_val[31];
            state_in = ST_BUILD_DIV;
         end
         ST_BUILD_DIV: begin
            m_in = m_ff + (div_d >> 1);
            div_start = 1'b0;
            state_in = ST_BUILD_RND;
         end
         ST_BUILD_RND: begin
            // start once, then wait for done
            if (q_ff[0] == 1'b0) begin
               div_start = 1'b1;
               q_in = 64'd1;
            end else if (div_done) begin
               q_in = '0;
               if (div_q == 0) b_in = '0;
               else if (neg_ff) b_in = (div_q >= 64'h8000_0000) ? 32'sh8000_0000
                                                                : 32'(-div_q);
               else b_in = (div_q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : div_q[31:0];
               state_in = ST_BUILD_WR;
            end
         end
         ST_MAC_RD: begin
            if (i_ff > n_ff) state_in = ST_FINISH;
            else state_in = ST_MAC_WAIT;
         end
         ST_MAC_WAIT: state_in = ST_MAC_MUL;
         ST_MAC_MUL: begin
            prod_in = 64'(signed'(c_rdata)) * 64'(signed'(h_rdata));
            state_in = ST_MAC_ACC;
         end
         ST_MAC_ACC: begin
            acc_in = sat_add64(acc_ff, prod_ff);
            i_in = i_ff + CW'(1);
            state_in = ST_MAC_RD;
         end
         ST_FINISH: begin
            if (xs[63]) begin
               sat_in = qo > 64'h8000_0000;
               y_in = sat_in ? 32'h8000_0000 : 32'(-qo);
            end else begin
               sat_in = qo > 64'h7FFF_FFFF;
               y_in = sat_in ? 32'h7FFF_FFFF : qo[31:0];
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               hw_en = 1'b1;
               wp_in = wp_ff + AW'(1);
               if (seen_ff < CW'(MaxTaps)) seen_in = seen_ff + CW'(1);
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
         taps_ff  <= '0;
         seen_ff  <= '0;
         wp_ff    <= '0;
         q_ff     <= '0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         taps_ff  <= taps_in;
         seen_ff  <= seen_in;
         wp_ff    <= wp_in;
         q_ff     <= q_in;
      end
      i_ff    <= i_in;
      n_ff    <= n_in;
      b_ff    <= b_in;
      w_ff    <= w_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      m_ff    <= m_in;
      neg_ff  <= neg_in;
      y_ff    <= y_in;
      sat_ff  <= sat_in;
   end

   assign rsp_colored_sample = y_ff;
   assign rsp_saturated      = sat_ff;

`ifndef ASSERT_OFF
   a_hs_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("req and rsp both open");
   a_taps_max: assert property (@(posedge clock) disable iff (reset)
      taps_ff <= CW'(MaxTaps)) else $error("tap count overflow");
   a_seen_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && seen_ff < CW'(MaxTaps))
      |=> seen_ff == $past(seen_ff) + CW'(1))
      else $error("sample count not advanced");
   a_ready_sticky: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(ready_ff)) |-> ready_ff)
      else $error("table ready dropped");
`endif

endmodule

FILE: tb/tb_power_law_noise_ar_filter.sv
`timescale 1ns / 1ps

module tb_power_law_noise_ar_filter
   import plnf_pkg::*;
;

   localparam int NumTaps = MaxTapsDefault;
   localparam int CycleLimit = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [23:0] req_white_sample = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_colored_sample;
   logic        rsp_saturated;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CsrAlpha;
   logic [30:0] csr_data = '0;

   power_law_noise_ar_filter DUT (.*);

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   typedef struct packed {
      logic [31:0] colored;
      logic        clipped;
   } noise_out_type;

   // samples waiting to be sent, colored samples waiting to come back
   logic [23:0]   pending_samples[$];
   noise_out_type expected_noise[$];

   // predictor state: registers, coefficient table, output history
   logic [15:0] alpha_reg;
   logic [30:0] thresh_reg;
   int          coefs[NumTaps];
   int          history[NumTaps];
   int unsigned n_coefs;
   bit          table_built;
   int unsigned wr_ptr;
   int unsigned seen;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned n_errors = 0;
   int unsigned n_sent = 0;
   int unsigned n_checked = 0;
   int unsigned n_clipped = 0;
   int unsigned cycles = 0;

   function automatic longint unsigned magnitude(input longint x);
      return (x < 0) ? 64'd0 - 64'(x) : 64'(x);
   endfunction

   function automatic longint clamp_sum(input longint a, input longint b);
      longint s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63])
         return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      return s;
   endfunction

   // Kasdin step: b_i = b_(i-1) * (i-1 + alpha/2) / i, Q2.30, rounded and clipped
   function automatic int kasdin_coef(input int prev, input int unsigned i, input int alpha);
      longint            f;
      longint unsigned   d, m, q;
      bit                neg;
      f = (longint'(i - 1) <<< 13) + longint'(alpha);
      d = longint'(i) << 13;
      m = magnitude(longint'(prev)) * magnitude(f);
      q = (m + d / 2) / d;
      neg = (prev < 0) != (f < 0);
      if (q == 0) return 0;
      if (neg) begin
         if (q >= 64'h8000_0000) return 32'sh8000_0000;
         return int'(-longint'(q));
      end
      if (q > 64'h7FFF_FFFF) return 32'sh7FFF_FFFF;
      return int'(q);
   endfunction

   task automatic build_coefs();
      int alpha;
      int b;
      alpha = int'($signed(alpha_reg));
      b = 1 << 30;
      n_coefs = 0;
      while (n_coefs < NumTaps &&
             (magnitude(longint'(b)) << 2) > longint'(thresh_reg)) begin
         coefs[n_coefs] = b;
         n_coefs++;
         b = kasdin_coef(b, n_coefs, alpha);
      end
      table_built = 1'b1;
   endtask

   // y = w - sum b_i * y(n-i), rounded to Q.19 and clipped to 32 bits
   task automatic shape_sample(input logic [23:0] w_bits);
      longint          w, acc, x, y;
      longint unsigned m, q;
      int unsigned     taps, idx;
      noise_out_type   r;
      w = longint'($signed(w_bits));
      acc = 0;
      r.clipped = 1'b0;
      if (!table_built) build_coefs();
      taps = (n_coefs > 0) ? n_coefs - 1 : 0;
      if (seen < taps) taps = seen;
      for (int unsigned i = 1; i <= taps; i++) begin
         idx = (wr_ptr + NumTaps - i) % NumTaps;
         acc = clamp_sum(acc, longint'(coefs[i]) * longint'(history[idx]));
      end
      x = clamp_sum(w <<< 30, (acc == {1'b1, 63'd0}) ? {1'b0, {63{1'b1}}} : -acc);
      m = magnitude(x);
      q = (m >> 30) + ((m >> 29) & 1);
      if (x < 0) begin
         if (q > 64'h8000_0000) begin
            q = 64'h8000_0000;
            r.clipped = 1'b1;
         end
         y = -longint'(q);
      end else begin
         if (q > 64'h7FFF_FFFF) begin
            q = 64'h7FFF_FFFF;
            r.clipped = 1'b1;
         end
         y = longint'(q);
      end
      history[wr_ptr] = int'(y);
      wr_ptr = (wr_ptr + 1) % NumTaps;
      if (seen < NumTaps) seen++;
      r.colored = y[31:0];
      expected_noise.push_back(r);
   endtask

   // Sender: valid held with payload until taken; new item or drop only after a take
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            shape_sample(req_white_sample);
            n_sent++;
         end
         if (!req_valid || req_ready) begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_white_sample <= pending_samples.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random back-pressure, compare each taken item with the oldest prediction
   always @(posedge clock) begin
      noise_out_type exp_r;
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("%0t: timeout after %0d cycles", $time, cycles);
         $display("FAILED: results differ");
         $finish;
      end
      if (!reset) begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_valid && rsp_ready) begin
            if (expected_noise.size() == 0) begin
               $display("%0t: unexpected item, got %h/%b", $time,
                        rsp_colored_sample, rsp_saturated);
               n_errors++;
            end else begin
               exp_r = expected_noise.pop_front();
               n_checked++;
               if (exp_r.clipped) n_clipped++;
               if (rsp_colored_sample !== exp_r.colored) begin
                  $display("%0t: colored_sample expected %h actual %h", $time,
                           exp_r.colored, rsp_colored_sample);
                  n_errors++;
               end
               if (rsp_saturated !== exp_r.clipped) begin
                  $display("%0t: saturated expected %b actual %b", $time,
                           exp_r.clipped, rsp_saturated);
                  n_errors++;
               end
            end
         end
      end
   end

   // register write to the DUT and the predictor's copy; the table uses them only when built on the first item
   task automatic write_csr(input logic idx, input logic [30:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CsrAlpha) alpha_reg = value[15:0];
      else thresh_reg = value;
   endtask

   task automatic wait_drained();
      while (pending_samples.size() > 0 || req_valid || expected_noise.size() > 0)
         @(posedge clock);
   endtask

   // white-ish sample: mostly small Gaussian-like values, some full-range noise
   function automatic logic [23:0] random_sample();
      int s;
      if ($urandom_range(9) < 3) return 24'($urandom);
      s = 0;
      for (int k = 0; k < 4; k++) s += $urandom_range(2 * 524288) - 524288;
      return 24'(s);
   endfunction

   task automatic queue_random(input int count);
      for (int k = 0; k < count; k++) pending_samples.push_back(random_sample());
   endtask

   initial begin
      alpha_reg = AlphaReset;
      thresh_reg = ThreshReset;
      n_coefs = 0;
      table_built = 1'b0;
      wr_ptr = 0;
      seen = 0;
      foreach (coefs[k]) coefs[k] = 0;
      foreach (history[k]) history[k] = 0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // alpha = -4 with threshold 1: b1 clips to the Q2.30 floor,
      // b3 is an exact zero that ends the table
      write_csr(CsrAlpha, 31'(16'sh C000));
      write_csr(CsrThresh, 31'd1);

      // directed: field extremes and single bits
      send_idle_pct = 36;
      recv_idle_pct = 80;
      pending_samples.push_back(24'h000000);
      pending_samples.push_back(24'h7FFFFF);
      pending_samples.push_back(24'h800000);
      pending_samples.push_back(24'h000001);
      pending_samples.push_back(24'hFFFFFF);
      pending_samples.push_back(24'h800000);
      pending_samples.push_back(24'h800000);
      pending_samples.push_back(24'h7FFFFF);
      pending_samples.push_back(24'h7FFFFF);
      pending_samples.push_back(24'h7FFFFF);
      for (int b = 0; b < 12; b++) pending_samples.push_back(24'(1) << (2 * b));
      queue_random(170);
      wait_drained();

      // writes after the build: no effect until a reset
      write_csr(CsrAlpha, 31'(16'sh4000));
      write_csr(CsrThresh, 31'h7FFF_FFFF);
      send_idle_pct = 80;
      recv_idle_pct = 36;
      queue_random(190);
      wait_drained();

      write_csr(CsrAlpha, 31'(AlphaReset));
      write_csr(CsrThresh, ThreshReset);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random(190);
      wait_drained();

      repeat (50) @(posedge clock);
      $display("Run: %0d samples sent, %0d colored samples checked, %0d clipped, %0d taps",
               n_sent, n_checked, n_clipped, n_coefs);
      if (n_errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/plnf_pkg.sv
rtl/plnf_divider.sv
rtl/plnf_ram.sv
rtl/power_law_noise_ar_filter.sv
tb/tb_power_law_noise_ar_filter.sv
